[sv/fhsm_pkg.sv]
`timescale 1ns / 1ps

package fhsm_pkg;

    localparam int HUE_LEVELS = 256;
    localparam int SAT_LEVELS = 256;

    localparam int NSTG      = 11;  // total pipeline stages
    localparam int DIV_STG   = 5;   // divider stages
    localparam int DIV_STEPS = 4;   // quotient bits per divider stage
    localparam int QW        = DIV_STG * DIV_STEPS;
    localparam int NLANE     = 3;   // hue A, hue B, saturation

    localparam logic [16:0] Q_ONE = 17'h10000;

    typedef enum logic [2:0] {
        REG_OUTER_MODE = 3'd0,
        REG_HUE_EDGE_0 = 3'd1,
        REG_HUE_EDGE_1 = 3'd2,
        REG_HUE_EDGE_2 = 3'd3,
        REG_HUE_EDGE_3 = 3'd4,
        REG_SAT_EDGE_LO = 3'd5,
        REG_SAT_EDGE_HI = 3'd6
    } t_reg_idx;

    // curve piece kind: zero, one, quadratic, one minus quadratic
    typedef enum logic [1:0] {
        K_ZERO = 2'd0,
        K_ONE  = 2'd1,
        K_Q    = 2'd2,
        K_OMQ  = 2'd3
    } t_kind;

    // rem holds n (then n^2, then remainder), den holds w (then w^2)
    typedef struct packed {
        t_kind        kind;
        logic [15:0]  rem;
        logic [15:0]  den;
        logic [QW-1:0] quo;
    } t_lane;

    function automatic t_lane fix_zero_w(input t_lane l);
        t_lane r;
        r = l;
        if (r.den == 16'd0) begin
            if (r.kind == K_Q)   r.kind = K_ZERO;
            if (r.kind == K_OMQ) r.kind = K_ONE;
        end
        return r;
    endfunction

    function automatic t_lane s_class(input logic [7:0] x, input logic [7:0] a,
                                      input logic [7:0] b);
        t_lane l;
        logic [8:0] x2;
        logic [8:0] ab;
        l  = '0;
        x2 = {x, 1'b0};
        ab = {1'b0, a} + {1'b0, b};
        if (x <= a) begin
            l.kind = K_ZERO;
        end else if (x >= b) begin
            l.kind = K_ONE;
        end else if (x2 <= ab) begin
            l.kind = K_Q;
            l.rem  = {8'd0, x - a};
            l.den  = {8'd0, b - a};
        end else begin
            l.kind = K_OMQ;
            l.rem  = {8'd0, b - x};
            l.den  = {8'd0, b - a};
        end
        return fix_zero_w(l);
    endfunction

    function automatic t_lane pi_class(input logic [7:0] x, input logic [7:0] a,
                                       input logic [7:0] b, input logic [7:0] c,
                                       input logic [7:0] d);
        t_lane l;
        logic [8:0] x2;
        logic [8:0] ab;
        logic [8:0] cd;
        logic [7:0] wl;
        logic [7:0] wr;
        l  = '0;
        x2 = {x, 1'b0};
        ab = {1'b0, a} + {1'b0, b};
        cd = {1'b0, c} + {1'b0, d};
        wl = (b > a) ? b - a : 8'd0;
        wr = (d > c) ? d - c : 8'd0;
        if (x <= a || x >= d) begin
            l.kind = K_ZERO;
        end else if (x >= b && x <= c) begin
            l.kind = K_ONE;
        end else if (x2 <= ab) begin
            l.kind = K_Q;
            l.rem  = {8'd0, x - a};
            l.den  = {8'd0, wl};
        end else if (x <= b) begin
            l.kind = K_OMQ;
            l.rem  = {8'd0, b - x};
            l.den  = {8'd0, wl};
        end else if (x >= c && x2 <= cd) begin
            l.kind = K_OMQ;
            l.rem  = {8'd0, x - c};
            l.den  = {8'd0, wr};
        end else begin
            l.kind = K_Q;
            l.rem  = {8'd0, d - x};
            l.den  = {8'd0, wr};
        end
        return fix_zero_w(l);
    endfunction

    function automatic logic [16:0] piece_val(input t_lane l);
        logic [16:0] q;
        logic [16:0] v;
        q = l.quo[QW-1:QW-17];
        if (q > Q_ONE) q = Q_ONE;
        case (l.kind)
            K_ZERO:  v = 17'd0;
            K_ONE:   v = Q_ONE;
            K_Q:     v = q;
            default: v = Q_ONE - q;
        endcase
        return v;
    endfunction

endpackage

[sv/fuzzy_hue_sat_membership_core.sv]
`timescale 1ns / 1ps

// Fuzzy hue/saturation color membership. Each transaction carries one pixel's
// hue and saturation and returns an 8-bit membership (0..255). In outer mode
// the hue term is Z(h;e0,e1)+S(h;e2,e3), in inner mode Pi(h;e0..e3); it is
// multiplied by S(s;lo,hi) and by 255, truncated and saturated at 255.
// Throughput is one pixel per clock while the output is not stalled.
// The depth comes from the quadratic pieces floor(2n^2*65536/w^2): three
// restoring dividers (two hue lanes, one saturation lane) run in parallel,
// 4 quotient bits per stage over 5 stages. Each stage holds its transaction
// only while the stage after it is full and blocked, so bubbles collapse and
// new pixels are taken while a finished result waits. Configuration writes
// must happen only while the pipe is empty; index 7 is ignored.
module fuzzy_hue_sat_membership_core
    import fhsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    // pixel input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_saturation,
    // membership output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_membership
);

    // ---------------- configuration registers ----------------
    logic       r_outer_mode;
    logic [7:0] r_he0, r_he1, r_he2, r_he3, r_slo, r_shi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_mode <= 1'b0;
            r_he0 <= 8'd0;
            r_he1 <= 8'd16;
            r_he2 <= 8'd224;
            r_he3 <= 8'd240;
            r_slo <= 8'd40;
            r_shi <= 8'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OUTER_MODE:  r_outer_mode <= i_cfg_data[0];
                REG_HUE_EDGE_0:  r_he0 <= i_cfg_data;
                REG_HUE_EDGE_1:  r_he1 <= i_cfg_data;
                REG_HUE_EDGE_2:  r_he2 <= i_cfg_data;
                REG_HUE_EDGE_3:  r_he3 <= i_cfg_data;
                REG_SAT_EDGE_LO: r_slo <= i_cfg_data;
                REG_SAT_EDGE_HI: r_shi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // a stage may load when it is empty or its successor may load
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;

    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NSTG-1];

    // ---------------- stage 0: capture, clamp levels ----------------
    logic [7:0]  r_h, r_s;
    logic [7:0]  n_h, n_s;

    always_comb begin
        n_h = i_hue;
        n_s = i_saturation;
        if ({9'd0, i_hue} >= 17'(HUE_LEVELS))        n_h = 8'(HUE_LEVELS - 1);
        if ({9'd0, i_saturation} >= 17'(SAT_LEVELS)) n_s = 8'(SAT_LEVELS - 1);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r_h <= n_h;
            r_s <= n_s;
        end
    end

    // ---------------- stage 1: pick curve piece per lane ----------------
    t_lane r_l1 [NLANE];
    t_lane n_l1 [NLANE];

    always_comb begin
        if (r_outer_mode) begin
            n_l1[0] = s_class(r_h, r_he0, r_he1);
            n_l1[1] = s_class(r_h, r_he2, r_he3);
        end else begin
            n_l1[0] = pi_class(r_h, r_he0, r_he1, r_he2, r_he3);
            n_l1[1] = '0;   // unused in inner mode, kind zero
        end
        n_l1[2] = s_class(r_s, r_slo, r_shi);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1] && r_vld[0]) r_l1 <= n_l1;
    end

    // ---------------- stage 2: squares ----------------
    t_lane r_l2 [NLANE];

    always_ff @(posedge i_clk) begin
        if (rdy[2] && r_vld[1]) begin
            for (int j = 0; j < NLANE; j++) begin
                r_l2[j].kind <= r_l1[j].kind;
                r_l2[j].rem  <= r_l1[j].rem[7:0] * r_l1[j].rem[7:0];
                r_l2[j].den  <= r_l1[j].den[7:0] * r_l1[j].den[7:0];
                r_l2[j].quo  <= '0;
            end
        end
    end

    // ---------------- stages 3..7: restoring dividers ----------------
    // remainder stays below w^2, one quotient bit per step
    t_lane r_ld  [DIV_STG][NLANE];
    t_lane w_din [DIV_STG][NLANE];

    assign w_din[0] = r_l2;

    for (genvar g = 0; g < DIV_STG; g++) begin : g_div
        t_lane n_ld [NLANE];

        if (g > 0) begin : g_chain
            assign w_din[g] = r_ld[g-1];
        end

        always_comb begin
            logic [16:0] t;
            for (int j = 0; j < NLANE; j++) begin
                n_ld[j] = w_din[g][j];
                for (int st = 0; st < DIV_STEPS; st++) begin
                    t = {n_ld[j].rem, 1'b0};
                    if (t >= {1'b0, n_ld[j].den}) begin
                        n_ld[j].rem = 16'(t - {1'b0, n_ld[j].den});
                        n_ld[j].quo = {n_ld[j].quo[QW-2:0], 1'b1};
                    end else begin
                        n_ld[j].rem = t[15:0];
                        n_ld[j].quo = {n_ld[j].quo[QW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[3+g] && r_vld[2+g]) r_ld[g] <= n_ld;
        end
    end

    // ---------------- stage 8: piece values, hue term ----------------
    logic [17:0] r_hue;
    logic [16:0] r_sat;
    logic [16:0] va, vb;

    assign va = piece_val(r_ld[DIV_STG-1][0]);
    assign vb = piece_val(r_ld[DIV_STG-1][1]);

    always_ff @(posedge i_clk) begin
        if (rdy[8] && r_vld[7]) begin
            r_hue <= r_outer_mode ? 18'(Q_ONE - va) + {1'b0, vb} : {1'b0, va};
            r_sat <= piece_val(r_ld[DIV_STG-1][2]);
        end
    end

    // ---------------- stage 9: hue * sat ----------------
    logic [34:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (rdy[9] && r_vld[8]) r_prod <= {17'd0, r_hue} * {18'd0, r_sat};
    end

    // ---------------- stage 10: scale by 255, saturate ----------------
    logic [7:0]  r_mem;
    logic [42:0] scl;
    logic [10:0] top;

    assign scl = {r_prod, 8'd0} - {8'd0, r_prod};
    assign top = scl[42:32];

    always_ff @(posedge i_clk) begin
        if (rdy[10] && r_vld[9]) r_mem <= (top > 11'd255) ? 8'd255 : top[7:0];
    end

    assign o_membership = r_mem;

    // ---------------- assertions ----------------
    a_inner_lane_b_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] && !r_outer_mode |-> r_l1[1].kind == K_ZERO)
        else $error("hue lane B active in inner mode");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] && (r_l2[0].kind == K_Q || r_l2[0].kind == K_OMQ)
        |-> r_l2[0].rem < r_l2[0].den)
        else $error("divider start remainder not below divisor");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> &r_vld)
        else $error("input stalled with a bubble in the pipe");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-2] && rdy[NSTG-1] |=> r_vld[NSTG-1])
        else $error("transaction lost at output stage");

endmodule

[test/membership_checker.sv]
`timescale 1ns / 1ps

module membership_checker
    import fhsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    input  logic       i_stall_in,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_saturation,
    input  logic       i_valid_out,
    input  logic       i_stall_out,
    input  logic [7:0] i_membership,
    output int         o_fail_count,
    output int         o_pending
);

    logic       outer_mode;
    logic [7:0] edge_h [4];
    logic [7:0] sat_lo, sat_hi;
    logic [7:0] membership_q [$];

    function automatic logic [16:0] quad(input logic [7:0] n, input logic [7:0] w);
        logic [63:0] v;
        if (w == 0) return 17'd0;
        v = ((64'd2 * n * n) << 16) / (64'(w) * w);
        return (v > 64'h10000) ? 17'h10000 : v[16:0];
    endfunction

    function automatic logic [16:0] s_of(input logic [7:0] x, input logic [7:0] a,
                                         input logic [7:0] b);
        if (x <= a) return 17'd0;
        if (x >= b) return 17'h10000;
        if (9'(2 * x) <= 9'(a) + 9'(b)) return quad(x - a, b - a);
        return 17'h10000 - quad(b - x, b - a);
    endfunction

    function automatic logic [16:0] pi_of(input logic [7:0] x, input logic [7:0] a,
                                          input logic [7:0] b, input logic [7:0] c,
                                          input logic [7:0] d);
        logic [7:0] wl, wr;
        wl = (b > a) ? b - a : 8'd0;
        wr = (d > c) ? d - c : 8'd0;
        if (x <= a || x >= d) return 17'd0;
        if (x >= b && x <= c) return 17'h10000;
        if (9'(2 * x) <= 9'(a) + 9'(b)) return quad(x - a, wl);
        if (x <= b) return 17'h10000 - quad(b - x, wl);
        if (x >= c && 9'(2 * x) <= 9'(c) + 9'(d)) return 17'h10000 - quad(x - c, wr);
        return quad(d - x, wr);
    endfunction

    function automatic logic [7:0] predict_membership(input logic [7:0] h,
                                                      input logic [7:0] s);
        logic [63:0] hue_term, prod;
        if (outer_mode)
            hue_term = 64'(17'h10000 - s_of(h, edge_h[0], edge_h[1]))
                     + 64'(s_of(h, edge_h[2], edge_h[3]));
        else
            hue_term = 64'(pi_of(h, edge_h[0], edge_h[1], edge_h[2], edge_h[3]));
        prod = (hue_term * 64'(s_of(s, sat_lo, sat_hi)) * 64'd255) >> 32;
        return (prod > 255) ? 8'd255 : prod[7:0];
    endfunction

    assign o_pending = membership_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            outer_mode   <= 1'b0;
            edge_h[0]    <= 8'd0;
            edge_h[1]    <= 8'd16;
            edge_h[2]    <= 8'd224;
            edge_h[3]    <= 8'd240;
            sat_lo       <= 8'd40;
            sat_hi       <= 8'd100;
            o_fail_count <= 0;
            membership_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_OUTER_MODE:  outer_mode <= i_cfg_data[0];
                    REG_HUE_EDGE_0:  edge_h[0]  <= i_cfg_data;
                    REG_HUE_EDGE_1:  edge_h[1]  <= i_cfg_data;
                    REG_HUE_EDGE_2:  edge_h[2]  <= i_cfg_data;
                    REG_HUE_EDGE_3:  edge_h[3]  <= i_cfg_data;
                    REG_SAT_EDGE_LO: sat_lo     <= i_cfg_data;
                    REG_SAT_EDGE_HI: sat_hi     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in)
                membership_q.push_back(predict_membership(i_hue, i_saturation));
            if (i_valid_out && !i_stall_out) begin
                if (membership_q.size() == 0) begin
                    $error("membership: unexpected transaction, actual %0d", i_membership);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (membership_q[0] !== i_membership) begin
                        $error("membership: expected %0d, actual %0d",
                               membership_q[0], i_membership);
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(membership_q.pop_front());
                end
            end
        end
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

// Drives pixels into the membership core through a few register settings,
// with random idling on both channels in some phases; the checker predicts and compares.
module testbench
    import fhsm_pkg::*;
;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_idx = '0;
    logic [7:0] cfg_data = '0;
    logic       pix_valid = 1'b0;
    logic [7:0] pix_hue = '0;
    logic [7:0] pix_sat = '0;
    logic       out_stall = 1'b0;
    logic       core_stall, core_valid;
    logic [7:0] core_membership;
    int         fail_count, pending;
    int         send_idle_pct = 0;   // sender gap chance, percent
    int         recv_idle_pct = 0;   // receiver stall chance, percent

    always #5 i_clk = ~i_clk;

    fuzzy_hue_sat_membership_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(pix_valid), .o_stall(core_stall),
        .i_hue(pix_hue), .i_saturation(pix_sat),
        .o_valid(core_valid), .i_stall(out_stall), .o_membership(core_membership)
    );

    membership_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(pix_valid), .i_stall_in(core_stall),
        .i_hue(pix_hue), .i_saturation(pix_sat),
        .i_valid_out(core_valid), .i_stall_out(out_stall),
        .i_membership(core_membership),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver back-pressure, redrawn every falling edge
    always @(negedge i_clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // one register write, only while the pipe is drained
    task automatic write_reg(input t_reg_idx idx, input logic [7:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic write_all(input logic om, input logic [7:0] e0, input logic [7:0] e1,
                             input logic [7:0] e2, input logic [7:0] e3,
                             input logic [7:0] lo, input logic [7:0] hi);
        write_reg(REG_OUTER_MODE, {7'd0, om});
        write_reg(REG_HUE_EDGE_0, e0);
        write_reg(REG_HUE_EDGE_1, e1);
        write_reg(REG_HUE_EDGE_2, e2);
        write_reg(REG_HUE_EDGE_3, e3);
        write_reg(REG_SAT_EDGE_LO, lo);
        write_reg(REG_SAT_EDGE_HI, hi);
    endtask

    // present one pixel; valid stays up across back-to-back transactions
    task automatic send_pixel(input logic [7:0] h, input logic [7:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_valid <= 1'b1;
        pix_hue   <= h;
        pix_sat   <= s;
        @(posedge i_clk);
        while (core_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        pix_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic random_pixels(input int count);
        for (int k = 0; k < count; k++) begin
            // now and then pin the hue to one end of its range
            if ($urandom_range(3) == 0)
                send_pixel(8'($urandom_range(1) * 255), 8'($urandom));
            else
                send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    task automatic random_config();
        write_all(1'($urandom_range(1)), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings, field extremes and curve regions
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd8, 8'd70);
        send_pixel(8'd12, 8'd50);
        send_pixel(8'd100, 8'd100);
        send_pixel(8'd230, 8'd90);
        send_pixel(8'd170, 8'd85);
        drain();
        // outer mode: overlapping curves make the sum exceed one -> saturate
        write_all(1'b1, 8'd0, 8'd200, 8'd10, 8'd100, 8'd0, 8'd1);
        send_pixel(8'd150, 8'd255);
        send_pixel(8'd50, 8'd255);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd1);
        drain();
        // equal and reversed breakpoints, zero spacing
        write_all(1'b0, 8'd50, 8'd50, 8'd40, 8'd30, 8'd255, 8'd255);
        send_pixel(8'd35, 8'd255);
        send_pixel(8'd50, 8'd255);
        send_pixel(8'd45, 8'd128);
        drain();
        write_all(1'b0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd200, 8'd10);
        send_pixel(8'd128, 8'd150);
        send_pixel(8'd255, 8'd255);
        drain();
        write_reg(t_reg_idx'(3'd7), 8'hff);   // unused index, must be ignored
        send_pixel(8'd1, 8'd201);
        drain();

        // random phases: sender/receiver idle mix, then swapped, then none
        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct = (ph < 3) ? 37 : (ph < 6) ? 58 : 0;
            recv_idle_pct = (ph < 3) ? 58 : (ph < 6) ? 37 : 0;
            if (ph == 4)
                write_all(1'b1, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
            else
                random_config();
            random_pixels(78);
            drain();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
sv/fhsm_pkg.sv
sv/fuzzy_hue_sat_membership_core.sv
test/membership_checker.sv
test/testbench.sv
